FILE: sv/csa_pkg.sv
// Shared types and fixed constants of the contiguous slot allocator.
// No dependencies; every other file refers to it by scoped names.
package csa_pkg;

    localparam int BYTES_W = 19;
    localparam int SLOT_W  = 10;
    localparam int RUN_W   = 8;

    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_SEARCH = 11'b000_0000_0100,
        S_SEGQ   = 11'b000_0000_1000,
        S_SEGB   = 11'b000_0001_0000,
        S_LIMIT  = 11'b000_0010_0000,
        S_COUNT  = 11'b000_0100_0000,
        S_WRITE  = 11'b000_1000_0000,
        S_MSTART = 11'b001_0000_0000,
        S_MERGE  = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_SEARCH,
        OP_SEGQ,
        OP_SEGB,
        OP_LIMIT,
        OP_COUNT,
        OP_WRITE,
        OP_MSTART,
        OP_MERGE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
        logic   out_grant;
    } dp_cmd_t;

    typedef struct packed {
        logic init_last;
        logic req_zero;
        logic req_free;
        logic slot_bad;
        logic hit;
        logic miss_end;
        logic write_last;
        logic at_seg_start;
        logic run_zero;
        logic merge_last;
    } dp_stat_t;

endpackage

FILE: sv/csa_if.sv
// Request and response channel interfaces of the slot allocator.
// Depends on csa_pkg for the payload widths.
interface csa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [csa_pkg::BYTES_W-1:0]   request_bytes;
    logic [csa_pkg::SLOT_W-1:0]    slot_index;

    modport source (output valid, output kind, output request_bytes, output slot_index,
                    input ready);
    modport sink   (input valid, input kind, input request_bytes, input slot_index,
                    output ready);
endinterface

interface csa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        granted;
    logic [csa_pkg::SLOT_W-1:0]  first_slot;

    modport source (output valid, output granted, output first_slot, input ready);
    modport sink   (input valid, input granted, input first_slot, output ready);
endinterface

FILE: sv/csa_datapath.sv
// Datapath of the slot allocator: run-count memory, search pointers, segment
// bounds, fill/merge walker and result register. Depends on csa_pkg.
module csa_datapath #(
    parameter int NUM_SLOTS     = 1024,
    parameter int SEGMENT_SLOTS = 128,
    parameter int SLOT_SHIFT    = 11,
    parameter int PAGE_BITS     = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csa_pkg::dp_cmd_t            cmd,
    output csa_pkg::dp_stat_t           stat,
    input  logic                        in_kind,
    input  logic [csa_pkg::BYTES_W-1:0] in_bytes,
    input  logic [csa_pkg::SLOT_W-1:0]  in_slot,
    output logic                        granted,
    output logic [csa_pkg::SLOT_W-1:0]  first_slot
);

    localparam int IW       = $clog2(NUM_SLOTS);
    localparam int RUN_W    = csa_pkg::RUN_W;
    localparam int NS_W     = csa_pkg::BYTES_W + 1 - SLOT_SHIFT;
    localparam int STR_SH   = (PAGE_BITS > SLOT_SHIFT) ? PAGE_BITS - SLOT_SHIFT : 0;
    localparam int STR_W    = STR_SH + 1;
    localparam int M1       = (IW > NS_W) ? IW : NS_W;
    localparam int M2       = (M1 > STR_W) ? M1 : STR_W;
    localparam int M3       = (M2 > csa_pkg::SLOT_W) ? M2 : csa_pkg::SLOT_W;
    localparam int PW       = M3 + 2;
    localparam int CMP_W    = (NS_W > RUN_W) ? NS_W : RUN_W;
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int SEG_RECIP = ((1 << RECIP_SH) + SEGMENT_SLOTS - 1) / SEGMENT_SLOTS;
    localparam logic [csa_pkg::BYTES_W:0] PAGE_LIMIT = (csa_pkg::BYTES_W + 1)'(1 << PAGE_BITS);
    localparam logic [csa_pkg::BYTES_W:0] ROUND_ADD  =
        (csa_pkg::BYTES_W + 1)'((1 << SLOT_SHIFT) - 1);
    localparam logic [PW-1:0] PW_NUM   = PW'(NUM_SLOTS);
    localparam logic [PW-1:0] PW_SEG   = PW'(SEGMENT_SLOTS);
    localparam logic [PW-1:0] PW_STR   = PW'(1 << STR_SH);
    localparam logic [PW-1:0] PW_ONE   = PW'(1);
    localparam logic [PW-1:0] PW_TWO   = PW'(2);
    localparam logic [RUN_W-1:0] SEG_LAST = RUN_W'(SEGMENT_SLOTS - 1);

    logic [RUN_W-1:0] mem [NUM_SLOTS];

    logic                        kind_reg, kind_next;
    logic [NS_W-1:0]             nslots_reg, nslots_next;
    logic [PW-1:0]               stride_reg, stride_next;
    logic [PW-1:0]               probe_reg, probe_next;
    logic [PW-1:0]               wrap_reg, wrap_next;
    logic [PW-1:0]               cand_reg, cand_next;
    logic                        cand_vld_reg, cand_vld_next;
    logic                        cand_last_reg, cand_last_next;
    logic                        probe_done_reg, probe_done_next;
    logic [PW-1:0]               base_reg, base_next;
    logic [IW-1:0]               q_reg, q_next;
    logic [PW-1:0]               seg_start_reg, seg_start_next;
    logic [PW-1:0]               seg_end_reg, seg_end_next;
    logic [PW-1:0]               top_reg, top_next;
    logic [PW-1:0]               wptr_reg, wptr_next;
    logic [RUN_W-1:0]            count_reg, count_next;
    logic [IW-1:0]               ns_reg, ns_next;
    logic                        granted_reg, granted_next;
    logic [csa_pkg::SLOT_W-1:0]  first_reg, first_next;
    logic [RUN_W-1:0]            rd_data_reg;

    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [RUN_W-1:0]            wr_data;
    logic [IW-1:0]               rd_addr;

    logic [csa_pkg::BYTES_W:0]   round_sum;
    logic [NS_W-1:0]             ns_in;
    logic                        big_req;
    logic [PW-1:0]               str_in;
    logic [PW-1:0]               rnd;
    logic [PW-1:0]               aligned;
    logic [PW-1:0]               start;
    logic [PW-1:0]               step;
    logic [PW-1:0]               step_w;
    logic                        hit;
    logic [IW+RECIP_W-1:0]       prod;
    logic [PW-1:0]               segs;
    logic [PW-1:0]               sege;
    logic [PW-1:0]               reach;
    logic [PW-1:0]               top_c;
    logic [RUN_W-1:0]            ival_a;
    logic [PW-1:0]               ival_b;
    logic [RUN_W-1:0]            ival;
    logic [PW-1:0]               slot_pw;
    logic [PW-1:0]               wptr_m1;
    logic [PW-1:0]               wptr_m2;

    always_comb
    begin
        round_sum = {1'b0, in_bytes} + ROUND_ADD;
        ns_in     = round_sum[csa_pkg::BYTES_W:SLOT_SHIFT];
        big_req   = (PAGE_BITS > SLOT_SHIFT) && ({1'b0, in_bytes} > PAGE_LIMIT);
        str_in    = big_req ? PW_STR : PW_ONE;
        rnd       = PW'(ns_reg) + str_in - PW_ONE;
        aligned   = rnd & ~(str_in - PW_ONE);
        start     = (aligned >= PW_NUM) ? '0 : aligned;
        step      = probe_reg + stride_reg;
        step_w    = (step >= PW_NUM) ? '0 : step;
        hit       = cand_vld_reg && (CMP_W'(rd_data_reg) >= CMP_W'(nslots_reg));
        prod      = (IW + RECIP_W)'(base_reg[IW-1:0]) * (IW + RECIP_W)'(SEG_RECIP);
        segs      = PW'(q_reg) * PW_SEG;
        sege      = ((segs + PW_SEG) > PW_NUM) ? PW_NUM : segs + PW_SEG;
        reach     = base_reg + PW'(nslots_reg);
        top_c     = (reach > seg_end_reg) ? seg_end_reg : reach;
        ival_a    = RUN_W'(SEGMENT_SLOTS) - count_reg;
        ival_b    = PW_NUM - wptr_reg;
        ival      = (PW'(ival_a) < ival_b) ? ival_a : ival_b[RUN_W-1:0];
        slot_pw   = PW'(in_slot);
        wptr_m1   = wptr_reg - PW_ONE;
        wptr_m2   = wptr_reg - PW_TWO;
    end

    always_comb
    begin
        stat.init_last    = (wptr_reg == PW_NUM - PW_ONE);
        stat.req_zero     = (ns_in == '0);
        stat.req_free     = in_kind;
        stat.slot_bad     = (slot_pw >= PW_NUM);
        stat.hit          = hit;
        stat.miss_end     = cand_vld_reg && cand_last_reg && !hit;
        stat.write_last   = (wptr_m1 == base_reg);
        stat.at_seg_start = (wptr_reg == seg_start_reg);
        stat.run_zero     = (rd_data_reg == '0);
        stat.merge_last   = (wptr_m1 == seg_start_reg);
    end

    always_comb
    begin
        kind_next       = kind_reg;
        nslots_next     = nslots_reg;
        stride_next     = stride_reg;
        probe_next      = probe_reg;
        wrap_next       = wrap_reg;
        cand_next       = cand_reg;
        cand_vld_next   = cand_vld_reg;
        cand_last_next  = cand_last_reg;
        probe_done_next = probe_done_reg;
        base_next       = base_reg;
        q_next          = q_reg;
        seg_start_next  = seg_start_reg;
        seg_end_next    = seg_end_reg;
        top_next        = top_reg;
        wptr_next       = wptr_reg;
        count_next      = count_reg;
        ns_next         = ns_reg;
        wr_en           = 1'b0;
        wr_addr         = wptr_m1[IW-1:0];
        wr_data         = '0;
        rd_addr         = probe_reg[IW-1:0];

        unique case (cmd.op)
            csa_pkg::OP_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = wptr_reg[IW-1:0];
                wr_data    = ival;
                wptr_next  = wptr_reg + PW_ONE;
                count_next = (count_reg == SEG_LAST) ? '0 : count_reg + RUN_W'(1);
            end
            csa_pkg::OP_LOAD:
            begin
                kind_next       = in_kind;
                nslots_next     = ns_in;
                stride_next     = str_in;
                probe_next      = start;
                wrap_next       = start;
                cand_vld_next   = 1'b0;
                probe_done_next = 1'b0;
                base_next       = slot_pw;
            end
            csa_pkg::OP_SEARCH:
            begin
                cand_next       = probe_reg;
                cand_vld_next   = !probe_done_reg;
                cand_last_next  = (step_w == wrap_reg);
                probe_next      = step_w;
                probe_done_next = probe_done_reg || (step_w == wrap_reg);
                if (hit)
                begin
                    base_next = cand_reg;
                end
            end
            csa_pkg::OP_SEGQ:
            begin
                q_next = prod[RECIP_SH +: IW];
            end
            csa_pkg::OP_SEGB:
            begin
                seg_start_next = segs;
                seg_end_next   = sege;
            end
            csa_pkg::OP_LIMIT:
            begin
                top_next = top_c;
                rd_addr  = top_c[IW-1:0];
            end
            csa_pkg::OP_COUNT:
            begin
                count_next = (kind_reg && (top_reg < seg_end_reg)) ? rd_data_reg : '0;
                wptr_next  = top_reg;
                if (!kind_reg)
                begin
                    ns_next = (top_reg < PW_NUM) ? top_reg[IW-1:0] : '0;
                end
            end
            csa_pkg::OP_WRITE:
            begin
                wr_en     = 1'b1;
                wr_data   = kind_reg ? count_reg + RUN_W'(1) : '0;
                count_next = kind_reg ? count_reg + RUN_W'(1) : count_reg;
                wptr_next = wptr_m1;
            end
            csa_pkg::OP_MSTART:
            begin
                rd_addr = wptr_m1[IW-1:0];
            end
            csa_pkg::OP_MERGE:
            begin
                rd_addr = wptr_m2[IW-1:0];
                if (rd_data_reg != '0)
                begin
                    wr_en      = 1'b1;
                    wr_data    = count_reg + RUN_W'(1);
                    count_next = count_reg + RUN_W'(1);
                    wptr_next  = wptr_m1;
                end
            end
            default:
            begin
            end
        endcase

        granted_next = granted_reg;
        first_next   = first_reg;
        if (cmd.out_load)
        begin
            granted_next = cmd.out_grant;
            first_next   = (cmd.out_grant && !kind_reg) ?
                           base_reg[csa_pkg::SLOT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg       <= '0;
            count_reg      <= '0;
            ns_reg         <= '0;
            cand_vld_reg   <= 1'b0;
            probe_done_reg <= 1'b0;
            granted_reg    <= 1'b0;
        end
        else
        begin
            wptr_reg       <= wptr_next;
            count_reg      <= count_next;
            ns_reg         <= ns_next;
            cand_vld_reg   <= cand_vld_next;
            probe_done_reg <= probe_done_next;
            granted_reg    <= granted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        nslots_reg     <= nslots_next;
        stride_reg     <= stride_next;
        probe_reg      <= probe_next;
        wrap_reg       <= wrap_next;
        cand_reg       <= cand_next;
        cand_last_reg  <= cand_last_next;
        base_reg       <= base_next;
        q_reg          <= q_next;
        seg_start_reg  <= seg_start_next;
        seg_end_reg    <= seg_end_next;
        top_reg        <= top_next;
        first_reg      <= first_next;
    end

    assign granted    = granted_reg;
    assign first_slot = first_reg;

    a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == csa_pkg::OP_WRITE) |-> (wptr_reg > base_reg) && (wptr_reg <= seg_end_reg))
        else $error("fill walker left the run");

    a_merge_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == csa_pkg::OP_MERGE) |-> (wptr_reg > seg_start_reg))
        else $error("merge crossed segment start");

    a_cand_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == csa_pkg::OP_SEARCH) && cand_vld_reg) |-> (cand_reg < PW_NUM))
        else $error("search candidate outside pool");

endmodule

FILE: sv/csa_ctrl.sv
// Controller state machine of the slot allocator: sequences init sweep,
// search, fill and merge, and owns the response valid. Depends on csa_pkg.
module csa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  csa_pkg::dp_stat_t   stat,
    output csa_pkg::dp_cmd_t    cmd
);

    csa_pkg::state_t state_reg, state_next;
    logic            grant_reg, grant_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        grant_next     = grant_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = csa_pkg::OP_NONE;
        cmd.out_load   = 1'b0;
        cmd.out_grant  = grant_reg;

        unique case (state_reg)
            csa_pkg::S_INIT:
            begin
                cmd.op = csa_pkg::OP_INIT;
                if (stat.init_last)
                begin
                    state_next = csa_pkg::S_IDLE;
                end
            end
            csa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = csa_pkg::OP_LOAD;
                    if (stat.req_zero || (stat.req_free && stat.slot_bad))
                    begin
                        grant_next = 1'b0;
                        state_next = csa_pkg::S_FINISH;
                    end
                    else if (stat.req_free)
                    begin
                        state_next = csa_pkg::S_SEGQ;
                    end
                    else
                    begin
                        state_next = csa_pkg::S_SEARCH;
                    end
                end
            end
            csa_pkg::S_SEARCH:
            begin
                cmd.op = csa_pkg::OP_SEARCH;
                if (stat.hit)
                begin
                    state_next = csa_pkg::S_SEGQ;
                end
                else if (stat.miss_end)
                begin
                    grant_next = 1'b0;
                    state_next = csa_pkg::S_FINISH;
                end
            end
            csa_pkg::S_SEGQ:
            begin
                cmd.op     = csa_pkg::OP_SEGQ;
                state_next = csa_pkg::S_SEGB;
            end
            csa_pkg::S_SEGB:
            begin
                cmd.op     = csa_pkg::OP_SEGB;
                state_next = csa_pkg::S_LIMIT;
            end
            csa_pkg::S_LIMIT:
            begin
                cmd.op     = csa_pkg::OP_LIMIT;
                state_next = csa_pkg::S_COUNT;
            end
            csa_pkg::S_COUNT:
            begin
                cmd.op     = csa_pkg::OP_COUNT;
                state_next = csa_pkg::S_WRITE;
            end
            csa_pkg::S_WRITE:
            begin
                cmd.op = csa_pkg::OP_WRITE;
                if (stat.write_last)
                begin
                    state_next = csa_pkg::S_MSTART;
                end
            end
            csa_pkg::S_MSTART:
            begin
                cmd.op     = csa_pkg::OP_MSTART;
                grant_next = 1'b1;
                if (stat.at_seg_start)
                begin
                    state_next = csa_pkg::S_FINISH;
                end
                else
                begin
                    state_next = csa_pkg::S_MERGE;
                end
            end
            csa_pkg::S_MERGE:
            begin
                cmd.op = csa_pkg::OP_MERGE;
                if (stat.run_zero || stat.merge_last)
                begin
                    state_next = csa_pkg::S_FINISH;
                end
            end
            csa_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = csa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csa_pkg::S_INIT;
            grant_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grant_reg     <= grant_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("response word overwritten before taken");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != csa_pkg::S_IDLE))
        else $error("accepted request word not started");

endmodule

FILE: sv/contiguous_slot_allocator_unit.sv
// Top level of the contiguous slot allocator.
// Allocate: the response word follows the probes, the segment lookup, the slot fills and the merge steps.
// A failed allocate scans the whole pool at the stride, one probe per cycle, before it answers.
// Free skips the probes; zero-size requests and frees of an out-of-range slot go straight to the response.
// One request word at a time; the next is taken while a response word still waits.
// After reset, a sweep loads the run counts of all NUM_SLOTS slots; req.ready stays low until it ends.
module contiguous_slot_allocator_unit #(
    parameter int NUM_SLOTS     = 1024,
    parameter int SEGMENT_SLOTS = 128,
    parameter int SLOT_SHIFT    = 11,
    parameter int PAGE_BITS     = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    csa_req_if.sink    req,
    csa_rsp_if.source  rsp
);

    csa_pkg::dp_cmd_t  cmd;
    csa_pkg::dp_stat_t stat;

    csa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csa_datapath #(
        .NUM_SLOTS     (NUM_SLOTS),
        .SEGMENT_SLOTS (SEGMENT_SLOTS),
        .SLOT_SHIFT    (SLOT_SHIFT),
        .PAGE_BITS     (PAGE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (req.kind),
        .in_bytes   (req.request_bytes),
        .in_slot    (req.slot_index),
        .granted    (rsp.granted),
        .first_slot (rsp.first_slot)
    );

endmodule
